### rtl/core/fthe_pkg.sv
// Package for the fixed-table Huffman encoder: code ROM, widths and result types.
package fthe_pkg;

    localparam int DataWidth  = 8;
    localparam int LenWidth   = 4;
    localparam int CodeWidth  = 11;
    localparam int PendWidth  = 7;
    localparam int CountWidth = 3;
    localparam int AccWidth   = PendWidth + CodeWidth;   // 18
    localparam int SumWidth   = 5;                       // up to 7 + 11 = 18

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic [LenWidth-1:0]  len;
        logic [CodeWidth-1:0] code;
    } code_entry_t;

    // Up to two result words produced by one input word
    typedef struct packed {
        logic [1:0]           count;
        logic [DataWidth-1:0] byte0;
        logic [DataWidth-1:0] byte1;
        logic                 pkt_end;
    } result_t;

    localparam code_entry_t END_CODE = '{len: 4'd4, code: 11'h00D};

    function automatic code_entry_t code_lookup(input logic [DataWidth-1:0] sym);
        code_entry_t e;
        e = '{len: 4'd0, code: 11'h000};
        case (sym)
            8'd0: e = '{4'd2, 11'h000};  8'd1: e = '{4'd5, 11'h01F};
            8'd2: e = '{4'd6, 11'h022};  8'd3: e = '{4'd7, 11'h034};
            8'd4: e = '{4'd7, 11'h075};  8'd5: e = '{4'd6, 11'h028};
            8'd6: e = '{4'd6, 11'h03B};  8'd7: e = '{4'd7, 11'h032};
            8'd8: e = '{4'd8, 11'h0E0};  8'd9: e = '{4'd8, 11'h062};
            8'd10: e = '{4'd7, 11'h056}; 8'd11: e = '{4'd8, 11'h079};
            8'd12: e = '{4'd9, 11'h19D}; 8'd13: e = '{4'd8, 11'h097};
            8'd14: e = '{4'd6, 11'h02A}; 8'd15: e = '{4'd7, 11'h057};
            8'd16: e = '{4'd8, 11'h071}; 8'd17: e = '{4'd8, 11'h05B};
            8'd18: e = '{4'd9, 11'h1CC}; 8'd19: e = '{4'd8, 11'h0A7};
            8'd20: e = '{4'd7, 11'h025}; 8'd21: e = '{4'd7, 11'h04F};
            8'd22: e = '{4'd8, 11'h066}; 8'd23: e = '{4'd8, 11'h07D};
            8'd24: e = '{4'd9, 11'h191}; 8'd25: e = '{4'd9, 11'h1CE};
            8'd26: e = '{4'd7, 11'h03F}; 8'd27: e = '{4'd9, 11'h090};
            8'd28: e = '{4'd8, 11'h059}; 8'd29: e = '{4'd8, 11'h07B};
            8'd30: e = '{4'd8, 11'h091}; 8'd31: e = '{4'd8, 11'h0C6};
            8'd32: e = '{4'd6, 11'h02D}; 8'd33: e = '{4'd9, 11'h186};
            8'd34: e = '{4'd8, 11'h06F}; 8'd35: e = '{4'd9, 11'h093};
            8'd36: e = '{4'd10, 11'h1CC}; 8'd37: e = '{4'd8, 11'h05A};
            8'd38: e = '{4'd10, 11'h1AE}; 8'd39: e = '{4'd10, 11'h1C0};
            8'd40: e = '{4'd9, 11'h148}; 8'd41: e = '{4'd9, 11'h14A};
            8'd42: e = '{4'd9, 11'h082}; 8'd43: e = '{4'd10, 11'h19F};
            8'd44: e = '{4'd9, 11'h171}; 8'd45: e = '{4'd9, 11'h120};
            8'd46: e = '{4'd9, 11'h0E7}; 8'd47: e = '{4'd10, 11'h1F3};
            8'd48: e = '{4'd9, 11'h14B}; 8'd49: e = '{4'd9, 11'h100};
            8'd50: e = '{4'd9, 11'h190}; 8'd51: e = '{4'd6, 11'h013};
            8'd52: e = '{4'd9, 11'h161}; 8'd53: e = '{4'd9, 11'h125};
            8'd54: e = '{4'd9, 11'h133}; 8'd55: e = '{4'd9, 11'h195};
            8'd56: e = '{4'd9, 11'h173}; 8'd57: e = '{4'd9, 11'h1CA};
            8'd58: e = '{4'd9, 11'h086}; 8'd59: e = '{4'd9, 11'h1E9};
            8'd60: e = '{4'd9, 11'h0DB}; 8'd61: e = '{4'd9, 11'h1EC};
            8'd62: e = '{4'd9, 11'h08B}; 8'd63: e = '{4'd9, 11'h085};
            8'd64: e = '{4'd5, 11'h00A}; 8'd65: e = '{4'd8, 11'h096};
            8'd66: e = '{4'd8, 11'h09C}; 8'd67: e = '{4'd9, 11'h1C3};
            8'd68: e = '{4'd9, 11'h19C}; 8'd69: e = '{4'd9, 11'h08F};
            8'd70: e = '{4'd9, 11'h18F}; 8'd71: e = '{4'd9, 11'h091};
            8'd72: e = '{4'd9, 11'h087}; 8'd73: e = '{4'd9, 11'h0C6};
            8'd74: e = '{4'd9, 11'h177}; 8'd75: e = '{4'd9, 11'h089};
            8'd76: e = '{4'd9, 11'h0D6}; 8'd77: e = '{4'd9, 11'h08C};
            8'd78: e = '{4'd9, 11'h1EE}; 8'd79: e = '{4'd9, 11'h1EB};
            8'd80: e = '{4'd9, 11'h084}; 8'd81: e = '{4'd9, 11'h164};
            8'd82: e = '{4'd9, 11'h175}; 8'd83: e = '{4'd9, 11'h1CD};
            8'd84: e = '{4'd8, 11'h05E}; 8'd85: e = '{4'd9, 11'h088};
            8'd86: e = '{4'd9, 11'h12B}; 8'd87: e = '{4'd9, 11'h172};
            8'd88: e = '{4'd9, 11'h10A}; 8'd89: e = '{4'd9, 11'h08D};
            8'd90: e = '{4'd9, 11'h13A}; 8'd91: e = '{4'd9, 11'h11C};
            8'd92: e = '{4'd10, 11'h1E1}; 8'd93: e = '{4'd10, 11'h1E0};
            8'd94: e = '{4'd9, 11'h187}; 8'd95: e = '{4'd10, 11'h1DC};
            8'd96: e = '{4'd10, 11'h1DF}; 8'd97: e = '{4'd7, 11'h074};
            8'd98: e = '{4'd9, 11'h19F}; 8'd99: e = '{4'd8, 11'h08D};
            8'd100: e = '{4'd8, 11'h0E4}; 8'd101: e = '{4'd7, 11'h079};
            8'd102: e = '{4'd9, 11'h0EA}; 8'd103: e = '{4'd9, 11'h0E1};
            8'd104: e = '{4'd8, 11'h040}; 8'd105: e = '{4'd7, 11'h041};
            8'd106: e = '{4'd9, 11'h10B}; 8'd107: e = '{4'd9, 11'h0B0};
            8'd108: e = '{4'd8, 11'h06A}; 8'd109: e = '{4'd8, 11'h0C1};
            8'd110: e = '{4'd7, 11'h071}; 8'd111: e = '{4'd7, 11'h078};
            8'd112: e = '{4'd8, 11'h0B1}; 8'd113: e = '{4'd9, 11'h14C};
            8'd114: e = '{4'd7, 11'h043}; 8'd115: e = '{4'd8, 11'h076};
            8'd116: e = '{4'd7, 11'h066}; 8'd117: e = '{4'd7, 11'h04D};
            8'd118: e = '{4'd9, 11'h08A}; 8'd119: e = '{4'd6, 11'h02F};
            8'd120: e = '{4'd8, 11'h0C9}; 8'd121: e = '{4'd9, 11'h0CE};
            8'd122: e = '{4'd9, 11'h149}; 8'd123: e = '{4'd9, 11'h160};
            8'd124: e = '{4'd10, 11'h1BA}; 8'd125: e = '{4'd10, 11'h19E};
            8'd126: e = '{4'd10, 11'h39F}; 8'd127: e = '{4'd9, 11'h0E5};
            8'd128: e = '{4'd9, 11'h194}; 8'd129: e = '{4'd9, 11'h184};
            8'd130: e = '{4'd9, 11'h126}; 8'd131: e = '{4'd7, 11'h030};
            8'd132: e = '{4'd8, 11'h06C}; 8'd133: e = '{4'd9, 11'h121};
            8'd134: e = '{4'd9, 11'h1E8}; 8'd135: e = '{4'd10, 11'h1C1};
            8'd136: e = '{4'd10, 11'h11D}; 8'd137: e = '{4'd10, 11'h163};
            8'd138: e = '{4'd10, 11'h385}; 8'd139: e = '{4'd10, 11'h3DB};
            8'd140: e = '{4'd10, 11'h17D}; 8'd141: e = '{4'd10, 11'h106};
            8'd142: e = '{4'd10, 11'h397}; 8'd143: e = '{4'd10, 11'h24E};
            8'd144: e = '{4'd7, 11'h02E}; 8'd145: e = '{4'd8, 11'h098};
            8'd146: e = '{4'd10, 11'h33C}; 8'd147: e = '{4'd10, 11'h32E};
            8'd148: e = '{4'd10, 11'h1E9}; 8'd149: e = '{4'd9, 11'h0BF};
            8'd150: e = '{4'd10, 11'h3DF}; 8'd151: e = '{4'd10, 11'h1DD};
            8'd152: e = '{4'd10, 11'h32D}; 8'd153: e = '{4'd10, 11'h2ED};
            8'd154: e = '{4'd10, 11'h30B}; 8'd155: e = '{4'd10, 11'h107};
            8'd156: e = '{4'd10, 11'h2E8}; 8'd157: e = '{4'd10, 11'h3DE};
            8'd158: e = '{4'd10, 11'h125}; 8'd159: e = '{4'd10, 11'h1E8};
            8'd160: e = '{4'd9, 11'h0E9}; 8'd161: e = '{4'd10, 11'h1CD};
            8'd162: e = '{4'd10, 11'h1B5}; 8'd163: e = '{4'd9, 11'h165};
            8'd164: e = '{4'd10, 11'h232}; 8'd165: e = '{4'd10, 11'h2E1};
            8'd166: e = '{4'd11, 11'h3AE}; 8'd167: e = '{4'd11, 11'h3C6};
            8'd168: e = '{4'd11, 11'h3E2}; 8'd169: e = '{4'd10, 11'h205};
            8'd170: e = '{4'd10, 11'h29A}; 8'd171: e = '{4'd10, 11'h248};
            8'd172: e = '{4'd10, 11'h2CD}; 8'd173: e = '{4'd10, 11'h23B};
            8'd174: e = '{4'd11, 11'h3C5}; 8'd175: e = '{4'd10, 11'h251};
            8'd176: e = '{4'd10, 11'h2E9}; 8'd177: e = '{4'd10, 11'h252};
            8'd178: e = '{4'd9, 11'h1EA}; 8'd179: e = '{4'd11, 11'h3A0};
            8'd180: e = '{4'd11, 11'h391}; 8'd181: e = '{4'd10, 11'h23C};
            8'd182: e = '{4'd11, 11'h392}; 8'd183: e = '{4'd11, 11'h3D5};
            8'd184: e = '{4'd10, 11'h233}; 8'd185: e = '{4'd10, 11'h2CC};
            8'd186: e = '{4'd11, 11'h390}; 8'd187: e = '{4'd10, 11'h1BB};
            8'd188: e = '{4'd11, 11'h3A1}; 8'd189: e = '{4'd11, 11'h3C4};
            8'd190: e = '{4'd10, 11'h211}; 8'd191: e = '{4'd10, 11'h203};
            8'd192: e = '{4'd9, 11'h12A}; 8'd193: e = '{4'd10, 11'h231};
            8'd194: e = '{4'd11, 11'h3E0}; 8'd195: e = '{4'd10, 11'h29B};
            8'd196: e = '{4'd11, 11'h3D7}; 8'd197: e = '{4'd10, 11'h202};
            8'd198: e = '{4'd11, 11'h3AD}; 8'd199: e = '{4'd10, 11'h213};
            8'd200: e = '{4'd10, 11'h253}; 8'd201: e = '{4'd10, 11'h32C};
            8'd202: e = '{4'd10, 11'h23D}; 8'd203: e = '{4'd10, 11'h23F};
            8'd204: e = '{4'd10, 11'h32F}; 8'd205: e = '{4'd10, 11'h11C};
            8'd206: e = '{4'd10, 11'h384}; 8'd207: e = '{4'd10, 11'h31C};
            8'd208: e = '{4'd10, 11'h17C}; 8'd209: e = '{4'd10, 11'h30A};
            8'd210: e = '{4'd10, 11'h2E0}; 8'd211: e = '{4'd10, 11'h276};
            8'd212: e = '{4'd10, 11'h250}; 8'd213: e = '{4'd11, 11'h3E3};
            8'd214: e = '{4'd10, 11'h396}; 8'd215: e = '{4'd10, 11'h18F};
            8'd216: e = '{4'd10, 11'h204}; 8'd217: e = '{4'd10, 11'h206};
            8'd218: e = '{4'd10, 11'h230}; 8'd219: e = '{4'd10, 11'h265};
            8'd220: e = '{4'd10, 11'h212}; 8'd221: e = '{4'd10, 11'h23E};
            8'd222: e = '{4'd11, 11'h3AC}; 8'd223: e = '{4'd11, 11'h393};
            8'd224: e = '{4'd11, 11'h3E1}; 8'd225: e = '{4'd10, 11'h1DE};
            8'd226: e = '{4'd11, 11'h3D6}; 8'd227: e = '{4'd10, 11'h31D};
            8'd228: e = '{4'd11, 11'h3E5}; 8'd229: e = '{4'd11, 11'h3E4};
            8'd230: e = '{4'd10, 11'h207}; 8'd231: e = '{4'd11, 11'h3C7};
            8'd232: e = '{4'd10, 11'h277}; 8'd233: e = '{4'd11, 11'h3D4};
            8'd234: e = '{4'd8, 11'h0C0}; 8'd235: e = '{4'd10, 11'h162};
            8'd236: e = '{4'd10, 11'h3DA}; 8'd237: e = '{4'd10, 11'h124};
            8'd238: e = '{4'd10, 11'h1B4}; 8'd239: e = '{4'd10, 11'h264};
            8'd240: e = '{4'd10, 11'h33D}; 8'd241: e = '{4'd10, 11'h1D1};
            8'd242: e = '{4'd10, 11'h1AF}; 8'd243: e = '{4'd10, 11'h39E};
            8'd244: e = '{4'd10, 11'h24F}; 8'd245: e = '{4'd11, 11'h373};
            8'd246: e = '{4'd10, 11'h249}; 8'd247: e = '{4'd11, 11'h372};
            8'd248: e = '{4'd9, 11'h167}; 8'd249: e = '{4'd10, 11'h210};
            8'd250: e = '{4'd10, 11'h23A}; 8'd251: e = '{4'd10, 11'h1B8};
            8'd252: e = '{4'd11, 11'h3AF}; 8'd253: e = '{4'd10, 11'h18E};
            8'd254: e = '{4'd10, 11'h2EC}; 8'd255: e = '{4'd7, 11'h062};
            default: e = '{4'd2, 11'h000};
        endcase
        return e;
    endfunction

endpackage

### rtl/core/fthe_pack.sv
// Bit packer: appends one code to the pending bits and cuts out whole bytes.
module fthe_pack
(
    input  logic                                  is_end,
    input  fthe_pkg::code_entry_t                 entry,
    input  logic [fthe_pkg::PendWidth-1:0]        pend_bits,
    input  logic [fthe_pkg::CountWidth-1:0]       pend_count,
    output fthe_pkg::result_t                     result,
    output logic [fthe_pkg::PendWidth-1:0]        pend_bits_next,
    output logic [fthe_pkg::CountWidth-1:0]       pend_count_next
);

    logic [fthe_pkg::AccWidth-1:0] acc;
    logic [fthe_pkg::AccWidth-1:0] aligned;
    logic [fthe_pkg::SumWidth-1:0] total;
    logic [fthe_pkg::SumWidth-1:0] rem;
    logic [1:0]                    full_bytes;
    logic [fthe_pkg::CountWidth-1:0] rem3;
    logic [fthe_pkg::AccWidth-1:0] mask;

    always_comb
    begin
        // accumulate: pending bits above the new code
        acc   = ({{fthe_pkg::CodeWidth{1'b0}}, pend_bits} << entry.len)
              | {{fthe_pkg::PendWidth{1'b0}}, entry.code};
        total = {2'b00, pend_count} + {1'b0, entry.len};
        full_bytes = total[4:3];
        rem   = {2'b00, total[2:0]};
        rem3  = total[2:0];
        // left-align so the oldest bit is at the top of the accumulator
        aligned = acc << (5'(fthe_pkg::AccWidth) - total);
        mask  = (18'd1 << rem3) - 18'd1;

        result.byte0   = aligned[17:10];
        result.byte1   = aligned[9:2];
        result.pkt_end = is_end;
        pend_bits_next  = 7'(acc & mask);
        pend_count_next = rem3;
        result.count    = full_bytes;

        // end of packet: flush the tail left-aligned with zero padding
        if (is_end)
        begin
            pend_bits_next  = '0;
            pend_count_next = '0;
            if (rem != '0)
            begin
                result.count = full_bytes + 2'd1;
                if (full_bytes == 2'd0)
                    result.byte0 = aligned[17:10];
                else
                    result.byte1 = aligned[9:2];
            end
        end
    end

endmodule

### rtl/core/fixed_table_huffman_encoder_top.sv
// Top level of the fixed-table Huffman encoder: handshake, state and output buffer.
//
//  channel  dir  tdata                          tuser
//  s_axis   in   [0] cmd, [8:1] data_byte       -
//  m_axis   out  [7:0] out_byte                 [0] run_end, [1] packet_end
//
// Each accepted word is encoded from the code ROM lookup and the packer into a
// two-entry result buffer; the buffer drains one byte a cycle while m_axis_tready
// is high, so a word giving two bytes holds off the next word until its first byte has left.
// rst_n clears pending bits and the buffer. A stalled output holds s_axis_tready
// low only once the buffer is still occupied at the next accept.
module fixed_table_huffman_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] cmd, [8:1] data_byte, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser    // [0] run_end, [1] packet_end
);

    logic [fthe_pkg::PendWidth-1:0]  pend_bits_reg,  pend_bits_next;
    logic [fthe_pkg::CountWidth-1:0] pend_count_reg, pend_count_next;
    logic [1:0]                      left_reg;
    logic [7:0]                      byte0_reg, byte1_reg;
    logic                            pkt_end_reg;
    logic                            in_fire;
    logic                            out_fire;
    logic                            is_end;
    fthe_pkg::code_entry_t           entry;
    fthe_pkg::result_t               result;

    assign is_end  = s_axis_tdata[0] == fthe_pkg::CMD_END;
    assign entry   = is_end ? fthe_pkg::END_CODE : fthe_pkg::code_lookup(s_axis_tdata[8:1]);
    assign out_fire = m_axis_tvalid && m_axis_tready;
    // accept when buffer empty or its last byte leaves this cycle
    assign s_axis_tready = (left_reg == 2'd0) || (left_reg == 2'd1 && m_axis_tready);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    fthe_pack u_pack
    (
        .is_end          (is_end),
        .entry           (entry),
        .pend_bits       (pend_bits_reg),
        .pend_count      (pend_count_reg),
        .result          (result),
        .pend_bits_next  (pend_bits_next),
        .pend_count_next (pend_count_next)
    );

    // pending state and result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            left_reg       <= '0;
            pkt_end_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            left_reg       <= result.count;
            pkt_end_reg    <= result.pkt_end;
        end
        else if (out_fire)
        begin
            left_reg <= left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte0_reg <= result.byte0;
            byte1_reg <= result.byte1;
        end
        else if (out_fire)
        begin
            byte0_reg <= byte1_reg;
        end
    end

    assign m_axis_tvalid = left_reg != 2'd0;
    assign m_axis_tdata  = byte0_reg;
    assign m_axis_tuser  = {pkt_end_reg && left_reg == 2'd1, left_reg == 2'd1};

    // never more than two bytes buffered
    assert property (@(posedge clk) disable iff (!rst_n) left_reg != 2'd3)
        else $error("result buffer overfilled");

    // an end word always leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_end |=> pend_count_reg == '0)
        else $error("pending bits left after end of packet");

    // an end word always produces a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_end |=> m_axis_tvalid)
        else $error("end of packet produced no byte");

endmodule
